// ===== src/tds_pkg.sv =====
package tds_pkg;

  localparam int WBITS         = 28;
  localparam int FRAC_BITS     = 16;
  localparam int MAX_SEQUENCES = 1024;

  localparam int DVD_W = 80;
  localparam int DSR_W = 36;
  localparam int QUO_W = 64;
  localparam int LEN_W = 7;
  localparam int MUL_W = 34;
  localparam int PRD_W = 64;

  localparam logic [LEN_W-1:0] LEN_RECIP    = 7'd29;
  localparam logic [LEN_W-1:0] LEN_MID      = 7'd40;
  localparam logic [LEN_W-1:0] LEN_B2       = 7'd50;
  localparam logic [LEN_W-1:0] LEN_WIDE     = 7'd60;
  localparam logic [LEN_W-1:0] LEN_THETA    = 7'd73;
  localparam logic [LEN_W-1:0] LEN_FIN_BASE = 7'd48;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_SAT     = 2'd2;

  typedef struct packed {
    logic             start;
    logic [LEN_W-1:0] len;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic ovf;
  } div_stat_t;

endpackage

// ===== src/tds_divider.sv =====
module tds_divider (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tds_pkg::div_req_t            req_i,
  input  logic [tds_pkg::DVD_W-1:0]    dividend_i,
  input  logic [tds_pkg::DSR_W-1:0]    divisor_i,
  output logic [tds_pkg::QUO_W-1:0]    quot_o,
  output tds_pkg::div_stat_t           stat_o
);

  localparam int DW = tds_pkg::DVD_W;
  localparam int SW = tds_pkg::DSR_W;
  localparam int QW = tds_pkg::QUO_W;
  localparam int LW = tds_pkg::LEN_W;

  logic          active_q;
  logic          done_q;
  logic [LW-1:0] cnt_q;
  logic [DW-1:0] dvd_q;
  logic [SW-1:0] rem_q;
  logic [SW-1:0] dsr_q;
  logic [QW-1:0] quot_q;
  logic          ovf_q;

  logic [SW:0]   trial;
  logic          ge;
  logic [SW:0]   diff;

  assign trial = {rem_q, dvd_q[DW-1]};
  assign ge    = trial >= {1'b0, dsr_q};
  assign diff  = trial - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        active_q <= 1'b1;
      end else if (active_q && cnt_q == LW'(1)) begin
        active_q <= 1'b0;
        done_q   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q  <= dividend_i << (LW'(DW) - req_i.len);
      cnt_q  <= req_i.len;
      rem_q  <= '0;
      dsr_q  <= divisor_i;
      quot_q <= '0;
      ovf_q  <= 1'b0;
    end else if (active_q) begin
      dvd_q  <= {dvd_q[DW-2:0], 1'b0};
      cnt_q  <= cnt_q - LW'(1);
      rem_q  <= ge ? diff[SW-1:0] : trial[SW-1:0];
      quot_q <= {quot_q[QW-2:0], ge};
      ovf_q  <= ovf_q | quot_q[QW-1];
    end
  end

  assign quot_o      = quot_q;
  assign stat_o.busy = active_q;
  assign stat_o.done = done_q;
  assign stat_o.ovf  = ovf_q;

endmodule

// ===== src/tds_multiplier.sv =====
module tds_multiplier (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [tds_pkg::MUL_W-1:0]  a_i,
  input  logic signed [tds_pkg::MUL_W-1:0]  b_i,
  output logic signed [tds_pkg::PRD_W-1:0]  prod_o
);

  localparam int FW = 2 * tds_pkg::MUL_W;

  logic signed [FW-1:0]              full;
  logic signed [tds_pkg::PRD_W-1:0]  prod_q;

  assign full = FW'(a_i) * FW'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= full[tds_pkg::PRD_W-1:0];
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== src/tajimas_d_statistic_top.sv =====
// Tajima's D for one alignment window.
// A request is taken at a rising edge where start is high and busy is low;
// it carries num_sequences_i, segregating_sites_i and mean_pairwise_diff_i.
// busy stays high while the request is worked on, and no new request is
// taken meanwhile. The result appears on d_value_o and status_o, marked by
// done_o for exactly one cycle; the receiver cannot stall it.
// An invalid request (n below 4, n above the maximum, or S zero) answers in
// the cycle after it is taken. For a valid one, the harmonic sums cost two
// divisions per term on the shared radix-2 divider, followed by eight more
// divisions, a 32-step square root that overlaps one division, and a final
// division of 50 to 80 steps.
// Reset clears the sequencer and the result strobe; no request is lost
// except one in flight.
module tajimas_d_statistic_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [10:0]         num_sequences_i,
  input  logic [15:0]         segregating_sites_i,
  input  logic [31:0]         mean_pairwise_diff_i,
  output logic                done_o,
  output logic signed [23:0]  d_value_o,
  output logic [1:0]          status_o
);

  localparam int DW = tds_pkg::DVD_W;
  localparam int SW = tds_pkg::DSR_W;
  localparam int QW = tds_pkg::QUO_W;
  localparam int MW = tds_pkg::MUL_W;
  localparam int W  = tds_pkg::WBITS;
  localparam int PISHIFT = tds_pkg::WBITS - tds_pkg::FRAC_BITS;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_MUL_KK = 5'd1;
  localparam logic [4:0] S_W_D1   = 5'd2;
  localparam logic [4:0] S_W_D2   = 5'd3;
  localparam logic [4:0] S_NN     = 5'd4;
  localparam logic [4:0] S_A1SQ   = 5'd5;
  localparam logic [4:0] S_B1     = 5'd6;
  localparam logic [4:0] S_W_B1   = 5'd7;
  localparam logic [4:0] S_W_B2   = 5'd8;
  localparam logic [4:0] S_W_C1   = 5'd9;
  localparam logic [4:0] S_W_T1   = 5'd10;
  localparam logic [4:0] S_W_T    = 5'd11;
  localparam logic [4:0] S_W_U    = 5'd12;
  localparam logic [4:0] S_W_E1   = 5'd13;
  localparam logic [4:0] S_W_E2   = 5'd14;
  localparam logic [4:0] S_V1     = 5'd15;
  localparam logic [4:0] S_V2     = 5'd16;
  localparam logic [4:0] S_V3     = 5'd17;
  localparam logic [4:0] S_NORM   = 5'd18;
  localparam logic [4:0] S_SQRT   = 5'd19;
  localparam logic [4:0] S_W_TH   = 5'd20;
  localparam logic [4:0] S_FIN    = 5'd21;
  localparam logic [4:0] S_W_FIN  = 5'd22;

  logic [4:0]  state_q, state_d;
  logic        done_q, done_d;

  logic [10:0]        n_q, n_d;
  logic [15:0]        s_q, s_d;
  logic [31:0]        pi_q, pi_d;
  logic [10:0]        k_q, k_d;
  logic [21:0]        nn_q, nn_d;
  logic [31:0]        a1_q, a1_d;
  logic [29:0]        a2_q, a2_d;
  logic [35:0]        a1sq_q, a1sq_d;
  logic [29:0]        b1_q, b1_d;
  logic [29:0]        b2_q, b2_d;
  logic [29:0]        t_q, t_d;
  logic signed [33:0] c1_q, c1_d;
  logic signed [33:0] c2_q, c2_d;
  logic signed [33:0] e1_q, e1_d;
  logic signed [63:0] var_q, var_d;
  logic [63:0]        cs_q, cs_d;
  logic [4:0]         kk_q, kk_d;
  logic [63:0]        sres_q, sres_d;
  logic [63:0]        sbit_q, sbit_d;
  logic               neg_q, neg_d;
  logic [45:0]        mag_q, mag_d;
  logic signed [23:0] d_q, d_d;
  logic [1:0]         st_q, st_d;

  tds_pkg::div_req_t  div_req;
  tds_pkg::div_stat_t div_stat;
  logic [DW-1:0]      div_dividend;
  logic [SW-1:0]      div_divisor;
  logic [QW-1:0]      quot;

  logic               mul_en;
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [63:0] prod;

  logic [SW-1:0]      b1_dsr, b2_dsr, e2_dsr;
  logic [33:0]        c1_mag, c2_mag;
  logic signed [33:0] q_signed;
  logic [63:0]        sq_sum;
  logic signed [46:0] num;
  logic [5:0]         fin_shift;
  logic               big;

  tds_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quot_o     (quot),
    .stat_o     (div_stat)
  );

  tds_multiplier u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign b1_dsr    = SW'(n_q - 11'd1) * SW'(3);
  assign b2_dsr    = (SW'(nn_q) - SW'(n_q)) * SW'(9);
  assign e2_dsr    = a1sq_q + SW'(a2_q);
  assign c1_mag    = c1_q[33] ? 34'(-c1_q) : 34'(c1_q);
  assign c2_mag    = c2_q[33] ? 34'(-c2_q) : 34'(c2_q);
  assign q_signed  = $signed(quot[33:0]);
  assign sq_sum    = sres_q + sbit_q;
  assign num       = $signed(47'({pi_q, PISHIFT'(0)})) - $signed(47'(quot[44:0]));
  assign fin_shift = 6'(kk_q) + 6'(tds_pkg::FRAC_BITS - W / 2);
  assign big       = div_stat.ovf || (quot[QW-1:24] != '0);

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    n_d = n_q; s_d = s_q; pi_d = pi_q; k_d = k_q; nn_d = nn_q;
    a1_d = a1_q; a2_d = a2_q; a1sq_d = a1sq_q; b1_d = b1_q; b2_d = b2_q;
    t_d = t_q; c1_d = c1_q; c2_d = c2_q; e1_d = e1_q; var_d = var_q;
    cs_d = cs_q; kk_d = kk_q; sres_d = sres_q; sbit_d = sbit_q;
    neg_d = neg_q; mag_d = mag_q; d_d = d_q; st_d = st_q;
    div_req      = '0;
    div_dividend = '0;
    div_divisor  = '0;
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          n_d  = num_sequences_i;
          s_d  = segregating_sites_i;
          pi_d = mean_pairwise_diff_i;
          k_d  = 11'd1;
          a1_d = '0;
          a2_d = '0;
          if (num_sequences_i < 11'd4
              || 32'(num_sequences_i) > 32'(tds_pkg::MAX_SEQUENCES)
              || segregating_sites_i == 16'd0) begin
            d_d    = '0;
            st_d   = tds_pkg::ST_INVALID;
            done_d = 1'b1;
          end else begin
            state_d = S_MUL_KK;
          end
        end
      end
      S_MUL_KK: begin
        mul_en = 1'b1;
        mul_a  = $signed(MW'(k_q));
        mul_b  = $signed(MW'(k_q));
        div_req.start = 1'b1;
        div_req.len   = tds_pkg::LEN_RECIP;
        div_dividend  = (DW'(1) << W) + DW'(k_q >> 1);
        div_divisor   = SW'(k_q);
        state_d = S_W_D1;
      end
      S_W_D1: begin
        if (div_stat.done) begin
          a1_d = a1_q + 32'(quot[28:0]);
          div_req.start = 1'b1;
          div_req.len   = tds_pkg::LEN_RECIP;
          div_dividend  = (DW'(1) << W) + DW'(prod[21:0] >> 1);
          div_divisor   = SW'(prod[21:0]);
          state_d = S_W_D2;
        end
      end
      S_W_D2: begin
        if (div_stat.done) begin
          a2_d = a2_q + 30'(quot[28:0]);
          if (k_q == n_q - 11'd1) begin
            state_d = S_NN;
          end else begin
            k_d = k_q + 11'd1;
            state_d = S_MUL_KK;
          end
        end
      end
      S_NN: begin
        mul_en = 1'b1;
        mul_a  = $signed(MW'(n_q));
        mul_b  = $signed(MW'(n_q));
        state_d = S_A1SQ;
      end
      S_A1SQ: begin
        nn_d   = prod[21:0];
        mul_en = 1'b1;
        mul_a  = $signed(MW'(a1_q));
        mul_b  = $signed(MW'(a1_q));
        state_d = S_B1;
      end
      S_B1: begin
        a1sq_d = 36'((64'(prod) + (64'(1) << (W - 1))) >> W);
        div_req.start = 1'b1;
        div_req.len   = tds_pkg::LEN_MID;
        div_dividend  = ((DW'(n_q) + DW'(1)) << W) + DW'(b1_dsr >> 1);
        div_divisor   = b1_dsr;
        state_d = S_W_B1;
      end
      S_W_B1: begin
        if (div_stat.done) begin
          b1_d = quot[29:0];
          div_req.start = 1'b1;
          div_req.len   = tds_pkg::LEN_B2;
          div_dividend  = ((DW'(nn_q) + DW'(n_q) + DW'(3)) << (W + 1))
                          + DW'(b2_dsr >> 1);
          div_divisor   = b2_dsr;
          state_d = S_W_B2;
        end
      end
      S_W_B2: begin
        if (div_stat.done) begin
          b2_d = quot[29:0];
          div_req.start = 1'b1;
          div_req.len   = tds_pkg::LEN_WIDE;
          div_dividend  = (DW'(1) << (2 * W)) + DW'(a1_q >> 1);
          div_divisor   = SW'(a1_q);
          state_d = S_W_C1;
        end
      end
      S_W_C1: begin
        if (div_stat.done) begin
          c1_d = $signed(34'(b1_q)) - $signed(34'(quot[29:0]));
          div_req.start = 1'b1;
          div_req.len   = tds_pkg::LEN_MID;
          div_dividend  = ((DW'(n_q) + DW'(2)) << W) + DW'(n_q >> 1);
          div_divisor   = SW'(n_q);
          state_d = S_W_T1;
        end
      end
      S_W_T1: begin
        if (div_stat.done) begin
          div_req.start = 1'b1;
          div_req.len   = tds_pkg::LEN_WIDE;
          div_dividend  = (DW'(quot[31:0]) << W) + DW'(a1_q >> 1);
          div_divisor   = SW'(a1_q);
          state_d = S_W_T;
        end
      end
      S_W_T: begin
        if (div_stat.done) begin
          t_d = quot[29:0];
          div_req.start = 1'b1;
          div_req.len   = tds_pkg::LEN_WIDE;
          div_dividend  = (DW'(a2_q) << W) + DW'(a1sq_q >> 1);
          div_divisor   = a1sq_q;
          state_d = S_W_U;
        end
      end
      S_W_U: begin
        if (div_stat.done) begin
          c2_d = $signed(34'(b2_q)) - $signed(34'(t_q)) + $signed(34'(quot[29:0]));
          div_req.start = 1'b1;
          div_req.len   = tds_pkg::LEN_WIDE;
          div_dividend  = (DW'(c1_mag) << W) + DW'(a1_q >> 1);
          div_divisor   = SW'(a1_q);
          state_d = S_W_E1;
        end
      end
      S_W_E1: begin
        if (div_stat.done) begin
          e1_d   = c1_q[33] ? 34'(-q_signed) : q_signed;
          mul_en = 1'b1;
          mul_a  = $signed(MW'(s_q));
          mul_b  = $signed(MW'(s_q - 16'd1));
          div_req.start = 1'b1;
          div_req.len   = tds_pkg::LEN_WIDE;
          div_dividend  = (DW'(c2_mag) << W) + DW'(e2_dsr >> 1);
          div_divisor   = e2_dsr;
          state_d = S_W_E2;
        end
      end
      S_W_E2: begin
        if (div_stat.done) begin
          mul_en = 1'b1;
          mul_a  = c2_q[33] ? 34'(-q_signed) : q_signed;
          mul_b  = $signed(prod[33:0]);
          state_d = S_V1;
        end
      end
      S_V1: begin
        var_d  = prod;
        mul_en = 1'b1;
        mul_a  = e1_q;
        mul_b  = $signed(MW'(s_q));
        state_d = S_V2;
      end
      S_V2: begin
        var_d   = var_q + prod;
        state_d = S_V3;
      end
      S_V3: begin
        if (var_q[63] || var_q == 64'sd0) begin
          d_d     = '0;
          st_d    = tds_pkg::ST_INVALID;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          cs_d = 64'(var_q);
          kk_d = '0;
          div_req.start = 1'b1;
          div_req.len   = tds_pkg::LEN_THETA;
          div_dividend  = (DW'(s_q) << (2 * W)) + DW'(a1_q >> 1);
          div_divisor   = SW'(a1_q);
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        if (cs_q < (64'(1) << 60)) begin
          cs_d = cs_q << 2;
          kk_d = kk_q + 5'd1;
        end else begin
          sres_d  = '0;
          sbit_d  = 64'(1) << 62;
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        if (cs_q >= sq_sum) begin
          cs_d   = cs_q - sq_sum;
          sres_d = (sres_q >> 1) + sbit_q;
        end else begin
          sres_d = sres_q >> 1;
        end
        sbit_d = sbit_q >> 2;
        if (sbit_q == 64'd1) begin
          state_d = S_W_TH;
        end
      end
      S_W_TH: begin
        if (!div_stat.busy) begin
          neg_d   = num[46];
          mag_d   = num[46] ? 46'(-num) : 46'(num);
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        div_req.start = 1'b1;
        div_req.len   = tds_pkg::LEN_FIN_BASE + 7'(fin_shift);
        div_dividend  = DW'(mag_q) << fin_shift;
        div_divisor   = sres_q[SW-1:0];
        state_d = S_W_FIN;
      end
      S_W_FIN: begin
        if (div_stat.done) begin
          st_d = tds_pkg::ST_OK;
          if (!neg_q) begin
            if (big || quot[23]) begin
              d_d  = 24'sh7FFFFF;
              st_d = tds_pkg::ST_SAT;
            end else begin
              d_d = $signed(quot[23:0]);
            end
          end else begin
            if (big || (quot[23] && quot[22:0] != '0)) begin
              d_d  = 24'sh800000;
              st_d = tds_pkg::ST_SAT;
            end else begin
              d_d = 24'(-$signed(quot[23:0]));
            end
          end
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q <= n_d; s_q <= s_d; pi_q <= pi_d; k_q <= k_d; nn_q <= nn_d;
    a1_q <= a1_d; a2_q <= a2_d; a1sq_q <= a1sq_d; b1_q <= b1_d; b2_q <= b2_d;
    t_q <= t_d; c1_q <= c1_d; c2_q <= c2_d; e1_q <= e1_d; var_q <= var_d;
    cs_q <= cs_d; kk_q <= kk_d; sres_q <= sres_d; sbit_q <= sbit_d;
    neg_q <= neg_d; mag_q <= mag_d; d_q <= d_d; st_q <= st_d;
  end

  assign busy      = state_q != S_IDLE;
  assign done_o    = done_q;
  assign d_value_o = d_q;
  assign status_o  = st_q;

endmodule

// ===== test/tb_tajimas_d_statistic_top.sv =====
module tb_tajimas_d_statistic_top;

  typedef struct packed {
    logic signed [23:0] d_value;
    logic [1:0]         status;
  } tajd_result_t;

  typedef struct {
    logic [10:0]        n;
    logic [15:0]        s;
    logic [31:0]        pi;
    bit                 typed;
    logic signed [23:0] d_value;
    logic [1:0]         status;
  } window_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [10:0]        num_sequences_i = '0;
  logic [15:0]        segregating_sites_i = '0;
  logic [31:0]        mean_pairwise_diff_i = '0;
  logic               done_o;
  logic signed [23:0] d_value_o;
  logic [1:0]         status_o;

  tajd_result_t expected_d_q[$];
  bit           row_typed = 1'b0;
  tajd_result_t row_result;
  int           error_count = 0;
  int           ok_count = 0;
  int           invalid_count = 0;
  int           sat_count = 0;
  int           request_count = 0;

  tajimas_d_statistic_top DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .num_sequences_i(num_sequences_i),
    .segregating_sites_i(segregating_sites_i),
    .mean_pairwise_diff_i(mean_pairwise_diff_i),
    .done_o(done_o),
    .d_value_o(d_value_o),
    .status_o(status_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic longint unsigned div_nearest(longint unsigned a, longint unsigned b);
    return (a + (b >> 1)) / b;
  endfunction

  function automatic longint signed div_signed_fix(longint signed x, longint unsigned y);
    longint unsigned mag;
    longint unsigned q;
    mag = (x < 0) ? longint'(-x) : longint'(x);
    q = div_nearest(mag << tds_pkg::WBITS, y);
    return (x < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned scaled_quotient(longint unsigned a, longint unsigned b,
                                                      int sh, longint unsigned cap);
    longint unsigned q;
    longint unsigned rem;
    q = a / b;
    rem = a % b;
    if (q > cap) return cap;
    for (int i = 0; i < sh; i++) begin
      rem <<= 1;
      q <<= 1;
      if (rem >= b) begin
        rem -= b;
        q |= 1;
      end
      if (q > cap) return cap;
    end
    return q;
  endfunction

  function automatic tajd_result_t tajimas_d(logic [10:0] n_in, logic [15:0] s_in,
                                             logic [31:0] pi_in);
    longint unsigned one, n, s, pi, a1, a2, a1sq, b1, b2, t, u, q0, rem, theta;
    longint unsigned cs, r, mag, q;
    longint signed c1, c2, e1, e2, var_fix, num;
    int sh, kk;
    bit neg;
    tajd_result_t res;
    one = 64'd1 << tds_pkg::WBITS;
    n = 64'(n_in);
    s = 64'(s_in);
    pi = 64'(pi_in);
    a1 = 0;
    a2 = 0;
    kk = 0;
    res.d_value = '0;
    res.status = tds_pkg::ST_INVALID;
    if (n < 4 || n > tds_pkg::MAX_SEQUENCES || s == 0) return res;
    for (longint unsigned k = 1; k < n; k++) begin
      a1 += div_nearest(one, k);
      a2 += div_nearest(one, k * k);
    end
    a1sq = (a1 * a1 + (one >> 1)) >> tds_pkg::WBITS;
    b1 = div_nearest((n + 1) << tds_pkg::WBITS, 3 * (n - 1));
    b2 = div_nearest((2 * (n * n + n + 3)) << tds_pkg::WBITS, 9 * n * (n - 1));
    c1 = longint'(b1) - longint'(div_nearest(one << tds_pkg::WBITS, a1));
    t = div_nearest(div_nearest((n + 2) << tds_pkg::WBITS, n) << tds_pkg::WBITS, a1);
    u = div_nearest(a2 << tds_pkg::WBITS, a1sq);
    c2 = longint'(b2) - longint'(t) + longint'(u);
    e1 = div_signed_fix(c1, a1);
    e2 = div_signed_fix(c2, a1sq + a2);
    var_fix = e1 * longint'(s) + e2 * longint'(s * (s - 1));
    if (var_fix <= 0) return res;
    q0 = (s << tds_pkg::WBITS) / a1;
    rem = (s << tds_pkg::WBITS) % a1;
    theta = (q0 << tds_pkg::WBITS) + div_nearest(rem << tds_pkg::WBITS, a1);
    num = longint'(pi << (tds_pkg::WBITS - tds_pkg::FRAC_BITS)) - longint'(theta);
    cs = var_fix;
    while (cs < (64'd1 << 60)) begin
      cs <<= 2;
      kk++;
    end
    r = int_sqrt(cs);
    neg = num < 0;
    mag = neg ? longint'(-num) : longint'(num);
    sh = tds_pkg::FRAC_BITS - tds_pkg::WBITS / 2 + kk;
    if (sh < 0) begin
      mag >>= -sh;
      sh = 0;
    end
    q = scaled_quotient(mag, r, sh, 64'd8388609);
    res.status = tds_pkg::ST_OK;
    if (!neg) begin
      if (q > 64'd8388607) begin
        q = 64'd8388607;
        res.status = tds_pkg::ST_SAT;
      end
      res.d_value = q[23:0];
    end else begin
      if (q > 64'd8388608) begin
        q = 64'd8388608;
        res.status = tds_pkg::ST_SAT;
      end
      res.d_value = -q[23:0];
    end
    return res;
  endfunction

  always @(posedge clk_i) begin
    tajd_result_t exp_r;
    if (done_o) begin
      if (expected_d_q.size() == 0) begin
        $display("%0t: result with nothing expected, actual d=%0d status=%0d",
                 $time, d_value_o, status_o);
        error_count++;
      end else begin
        exp_r = expected_d_q.pop_front();
        if (d_value_o !== exp_r.d_value || status_o !== exp_r.status) begin
          $display("%0t: mismatch, expected d=%0d status=%0d, actual d=%0d status=%0d",
                   $time, exp_r.d_value, exp_r.status, d_value_o, status_o);
          error_count++;
        end
        case (exp_r.status)
          tds_pkg::ST_OK:      ok_count++;
          tds_pkg::ST_INVALID: invalid_count++;
          default:             sat_count++;
        endcase
      end
    end
    if (rst_ni && start && !busy) begin
      if (row_typed) expected_d_q.push_back(row_result);
      else expected_d_q.push_back(tajimas_d(num_sequences_i, segregating_sites_i,
                                            mean_pairwise_diff_i));
      request_count++;
    end
  end

  task automatic send_window(window_row_t w);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    num_sequences_i = w.n;
    segregating_sites_i = w.s;
    mean_pairwise_diff_i = w.pi;
    row_typed = w.typed;
    row_result.d_value = w.d_value;
    row_result.status = w.status;
    start = 1'b1;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    @(negedge clk_i);
  endtask

  function automatic window_row_t mk_row(int n, int s, longint unsigned pi);
    window_row_t w;
    w.n = 11'(n);
    w.s = 16'(s);
    w.pi = 32'(pi);
    w.typed = 1'b0;
    w.d_value = '0;
    w.status = tds_pkg::ST_OK;
    return w;
  endfunction

  function automatic window_row_t mk_invalid(int n, int s, longint unsigned pi);
    window_row_t w;
    w = mk_row(n, s, pi);
    w.typed = 1'b1;
    w.status = tds_pkg::ST_INVALID;
    return w;
  endfunction

  initial begin
    window_row_t directed[$];
    window_row_t w;
    int sel;
    directed.push_back(mk_invalid(0, 5, 32'h0001_0000));
    directed.push_back(mk_invalid(1, 5, 32'h0001_0000));
    directed.push_back(mk_invalid(2, 7, 32'h0002_0000));
    directed.push_back(mk_invalid(3, 65535, 32'hFFFF_FFFF));
    directed.push_back(mk_invalid(1025, 10, 32'h0003_0000));
    directed.push_back(mk_invalid(2047, 65535, 32'hFFFF_FFFF));
    directed.push_back(mk_invalid(10, 0, 32'h0001_8000));
    directed.push_back(mk_row(4, 1, 32'h0000_0000));
    directed.push_back(mk_row(4, 1, 32'hFFFF_FFFF));
    directed.push_back(mk_row(4, 65535, 32'h0000_0000));
    directed.push_back(mk_row(4, 65535, 32'hFFFF_FFFF));
    directed.push_back(mk_row(5, 3, 32'h0001_AAAA));
    directed.push_back(mk_row(10, 12, 32'h0004_2000));
    directed.push_back(mk_row(10, 12, 32'h0000_0001));
    directed.push_back(mk_row(20, 1, 32'h0000_4000));
    directed.push_back(mk_row(1024, 1, 32'h0000_0000));
    directed.push_back(mk_row(1024, 65535, 32'hFFFF_FFFF));
    directed.push_back(mk_row(1024, 500, 32'h0064_0000));

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) send_window(directed[i]);

    for (int i = 0; i < 400; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 2) w = mk_row($urandom_range(600, 1024), $urandom_range(1, 65535), $urandom());
      else if (sel < 12) w = mk_row($urandom_range(0, 2047), $urandom_range(0, 65535), $urandom());
      else if (sel < 16) w = mk_row($urandom_range(4, 30), 0, $urandom());
      else begin
        w = mk_row($urandom_range(4, 24), $urandom_range(1, 40), 0);
        if ($urandom_range(0, 4) == 0) w.s = 16'($urandom_range(1, 65535));
        w.pi = 32'((longint'(w.s) << 16) / $urandom_range(1, 6) + $urandom_range(0, 32'hFFFF));
        if ($urandom_range(0, 9) == 0) w.pi = $urandom();
      end
      send_window(w);
      if (i == 200) begin
        start = 1'b0;
        while (expected_d_q.size() != 0) @(negedge clk_i);
      end
    end
    start = 1'b0;
    while (expected_d_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);

    $display("Sent %0d requests: %0d ok, %0d invalid, %0d saturated results.",
             request_count, ok_count, invalid_count, sat_count);
    $display("Sample sizes ranged from 0 to 2047 with random sender gaps.");
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #(12 * 40_000_000);
    $display("Regression FAIL");
    $finish;
  end

endmodule
